// ===== src/ppid_pkg.sv =====
package ppid_pkg;

	// field widths
	localparam int SP_W       = 8;
	localparam int IN_DATA_W  = 2 * SP_W;
	localparam int ERR_W      = SP_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int SUM_W      = 17;
	localparam int SUMX_W     = SUM_W + 1;
	localparam int GAIN_W     = 16;
	localparam int BASE_W     = 12;
	localparam int ILIM_W     = 12;
	localparam int SLIM_W     = 16;
	localparam int DRV_W      = 16;
	localparam int PROD_W     = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam int GAIN_FRAC_BITS_DEF = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_P_GAIN       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITERM_LIMIT  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MIN = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_MAX = 4'd7;

	// register reset values
	localparam logic [GAIN_W-1:0] P_GAIN_RST       = 16'd4096;
	localparam logic [GAIN_W-1:0] I_GAIN_RST       = 16'd0;
	localparam logic [GAIN_W-1:0] D_GAIN_RST       = 16'd0;
	localparam logic [BASE_W-1:0] BASE_VALUE_RST   = 12'd1500;
	localparam logic [ILIM_W-1:0] ITERM_LIMIT_RST  = 12'd200;
	localparam logic [SLIM_W-1:0] SUM_LIMIT_RST    = 16'd1000;
	localparam logic [SP_W-1:0]   SETPOINT_MIN_RST = 8'd15;
	localparam logic [SP_W-1:0]   SETPOINT_MAX_RST = 8'd105;

	// drive saturation bounds
	localparam logic signed [DRV_W-1:0] DRIVE_MAX = 16'sh7FFF;
	localparam logic signed [DRV_W-1:0] DRIVE_MIN = 16'sh8000;

endpackage

// ===== src/position_pid_with_clamps_core.sv =====
// positional pid for one tracking axis
//
// input stream (s_axis): one beat carries setpoint and measured position.
// output stream (m_axis): one beat per input beat carrying the saturated
// signed 16-bit drive, base + p + i + d, in input order.
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes one of
// eight registers (gains, base, clamps, setpoint window); cfg_ready is
// always high and writes to indexes 8..15 are dropped. write only when idle.
//
// an accepted beat is registered in the input stage, then in the output register
// when the output is free. throughput: one beat per cycle while not stalled. the
// whole pid pass (three gain multiplies, clamps, sum and saturation) sits between
// the input stage register and the output register, and the integrator state updates
// in the same cycle the result is registered, so the next beat sees it at once.
//
// reset: registers go to their documented defaults, error sum and last error
// clear, both stages empty.
// stall: when m_axis_tready is low the output holds; one more beat can wait
// in the input stage, after which s_axis_tready drops.
module position_pid_with_clamps_core #(
	parameter int GAIN_FRAC_BITS = ppid_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ppid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppid_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ppid_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // setpoint[7:0], measured[15:8]
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [ppid_pkg::DRV_W-1:0]       m_axis_tdata   // drive[15:0], signed
);
	import ppid_pkg::*;

	// term magnitudes after the gain shift, signed terms, and the sum of four
	localparam int MAG_W  = PROD_W - GAIN_FRAC_BITS;
	localparam int TERM_W = MAG_W + 1;
	localparam int ACC_W  = MAG_W + 3;

	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(DRIVE_MAX);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(DRIVE_MIN);

	// configuration registers
	logic [GAIN_W-1:0] p_gain_q, i_gain_q, d_gain_q;
	logic [BASE_W-1:0] base_value_q;
	logic [ILIM_W-1:0] iterm_limit_q;
	logic [SLIM_W-1:0] sum_limit_q;
	logic [SP_W-1:0]   sp_min_q, sp_max_q;

	// integrator state
	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0] prev_err_q;

	// stages
	logic              valid_s1;
	logic [SP_W-1:0]   setpoint_s1, measured_s1;
	logic              valid_s2;
	logic [DRV_W-1:0]  drive_s2;

	logic in_accept, out_free, advance;

	// datapath
	logic [SP_W-1:0]          sp_hi, sp_clamp;
	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-1:0]         err_mag;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_mag;
	logic [SUM_W-1:0]         sum_mag;
	logic [PROD_W-1:0]        p_prod, i_prod, d_prod;
	logic [PROD_W-1:0]        p_shr, i_shr, d_shr;
	logic [MAG_W-1:0]         p_mag, i_mag, d_mag;
	logic signed [TERM_W-1:0] p_term, i_raw, i_term, d_term, ilim;
	logic signed [ACC_W-1:0]  acc;
	logic signed [DRV_W-1:0]  drive;
	logic signed [SUMX_W-1:0] sum_raw, slim, sum_clamp;

	// ---------------------------------------------------------------
	// handshakes: output register frees when empty or taken
	// ---------------------------------------------------------------
	assign cfg_ready     = 1'b1;
	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = drive_s2;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q      <= P_GAIN_RST;
			i_gain_q      <= I_GAIN_RST;
			d_gain_q      <= D_GAIN_RST;
			base_value_q  <= BASE_VALUE_RST;
			iterm_limit_q <= ITERM_LIMIT_RST;
			sum_limit_q   <= SUM_LIMIT_RST;
			sp_min_q      <= SETPOINT_MIN_RST;
			sp_max_q      <= SETPOINT_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_P_GAIN:       p_gain_q      <= cfg_data[GAIN_W-1:0];
				REG_I_GAIN:       i_gain_q      <= cfg_data[GAIN_W-1:0];
				REG_D_GAIN:       d_gain_q      <= cfg_data[GAIN_W-1:0];
				REG_BASE_VALUE:   base_value_q  <= cfg_data[BASE_W-1:0];
				REG_ITERM_LIMIT:  iterm_limit_q <= cfg_data[ILIM_W-1:0];
				REG_SUM_LIMIT:    sum_limit_q   <= cfg_data[SLIM_W-1:0];
				REG_SETPOINT_MIN: sp_min_q      <= cfg_data[SP_W-1:0];
				REG_SETPOINT_MAX: sp_max_q      <= cfg_data[SP_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// pid pass
	// ---------------------------------------------------------------
	// window clamp, upper bound first so an inverted window lands on min
	assign sp_hi    = (setpoint_s1 > sp_max_q) ? sp_max_q : setpoint_s1;
	assign sp_clamp = (sp_hi < sp_min_q) ? sp_min_q : sp_hi;

	assign err     = $signed({1'b0, sp_clamp}) - $signed({1'b0, measured_s1});
	assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

	assign diff     = DIFF_W'(err) - DIFF_W'(prev_err_q);
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	// error sum stays within +/- sum_limit, so its magnitude fits in 16 bits
	assign sum_mag = error_sum_q[SUM_W-1] ? SUM_W'(-error_sum_q) : SUM_W'(error_sum_q);

	// sign-magnitude products give truncation toward zero after the shift
	assign p_prod = PROD_W'(p_gain_q) * PROD_W'(err_mag[ERR_W-2:0]);
	assign i_prod = PROD_W'(i_gain_q) * PROD_W'(sum_mag[SUM_W-2:0]);
	assign d_prod = PROD_W'(d_gain_q) * PROD_W'(diff_mag[DIFF_W-2:0]);

	assign p_shr = p_prod >> GAIN_FRAC_BITS;
	assign i_shr = i_prod >> GAIN_FRAC_BITS;
	assign d_shr = d_prod >> GAIN_FRAC_BITS;

	assign p_mag = p_shr[MAG_W-1:0];
	assign i_mag = i_shr[MAG_W-1:0];
	assign d_mag = d_shr[MAG_W-1:0];

	assign p_term = err[ERR_W-1]          ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
	assign i_raw  = error_sum_q[SUM_W-1]  ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});
	assign d_term = diff[DIFF_W-1]        ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});

	// symmetric clamp on the integral term
	assign ilim   = $signed({{(TERM_W-ILIM_W){1'b0}}, iterm_limit_q});
	assign i_term = (i_raw > ilim) ? ilim : ((i_raw < -ilim) ? -ilim : i_raw);

	assign acc = $signed({{(ACC_W-BASE_W){1'b0}}, base_value_q})
	           + ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term);

	assign drive = (acc > ACC_MAX) ? DRIVE_MAX :
	               ((acc < ACC_MIN) ? DRIVE_MIN : acc[DRV_W-1:0]);

	// integrator update, clamped to +/- sum_limit
	assign sum_raw   = SUMX_W'(error_sum_q) + SUMX_W'(err);
	assign slim      = $signed({{(SUMX_W-SLIM_W){1'b0}}, sum_limit_q});
	assign sum_clamp = (sum_raw > slim) ? slim : ((sum_raw < -slim) ? -slim : sum_raw);

	// ---------------------------------------------------------------
	// stage valids and state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				error_sum_q <= sum_clamp[SUM_W-1:0];
				prev_err_q  <= err;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			setpoint_s1 <= s_axis_tdata[SP_W-1:0];
			measured_s1 <= s_axis_tdata[IN_DATA_W-1:SP_W];
		end
		if (advance) begin
			drive_s2 <= drive;
		end
	end

endmodule

// ===== src/ppid_chk.sv =====
module ppid_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [ppid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [ppid_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [ppid_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ppid_pkg::DRV_W-1:0]       m_axis_tdata
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// input only backs up behind a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// a fresh result follows an accepted input beat, through the input and output stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching input beat");

	// config channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

	// offered input and config beats carry known payloads
	a_no_x: assert property (@(posedge clk) disable iff (!arst_n)
		!((s_axis_tvalid && $isunknown(s_axis_tdata))
		  || (cfg_valid && $isunknown({cfg_index, cfg_data}))))
		else $error("unknown payload on an offered beat");

endmodule

bind position_pid_with_clamps_core ppid_chk u_ppid_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
